// File: sv/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // width of the cursor as it is reported
    localparam int CURSOR_W = 11;

    // character codes
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;

    // configuration register map
    localparam logic REG_DEFAULT_ATTR = 1'b0;
    localparam logic [7:0] DEFAULT_ATTR_RESET = 8'd15;

    // request modes
    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_ERASE = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_MUL,
        S_EXEC,
        S_RD_WAIT,
        S_ERASE_RD,
        S_ERASE_WR,
        S_FILL,
        S_SCROLL,
        S_ZERO,
        S_DONE
    } state_t;

    // one request as it enters the sequencer
    typedef struct packed {
        mode_t      mode;
        logic [7:0] character;
        logic [7:0] attribute;
        logic       use_position;
        logic [6:0] column;
        logic [4:0] line;
        logic [7:0] count;
    } cmd_t;

    // one result as it leaves the sequencer
    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_cell;
        logic                scrolled;
        logic [7:0]          cell_char;
        logic [7:0]          cell_attribute;
    } res_t;

endpackage

`default_nettype wire

// File: sv/text_console_writer_core.sv
// Text console writer: a COLUMNS x ROWS screen of character/attribute cells
// and a cursor, driven one request at a time.
// Input channel (in_valid / in_stall) carries a request: mode 0 writes a
// character or newline, mode 1 blanks cells before the cursor, mode 2
// clears the screen, mode 3 reads a cell. Every request gives one result on
// the output channel (out_valid / out_stall) through an output register.
// A positioned write or newline first works out the cell index, an erase
// reads and then blanks each cell, a clear sweeps every cell, and a write
// that scrolls copies the screen up one row and zeroes the last row. The
// sequencer walks the cell store one cell at a time through its single
// write port and registered read port.
// After reset the cursor is 0, default_attribute is 15 and a clearing pass
// zeroes the store with in_stall high; APB writes are taken throughout.
// When the receiver stalls, the result is held in the output register; the
// next request is still accepted and worked on, and its result waits inside
// until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_core
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // request channel
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [1:0]          mode,
    input  wire logic [7:0]          character,
    input  wire logic [7:0]          attribute,
    input  wire logic                use_position,
    input  wire logic [6:0]          column,
    input  wire logic [4:0]          line,
    input  wire logic [7:0]          count,
    // result channel
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [CURSOR_W-1:0]      cursor_cell,
    output logic                     scrolled,
    output logic [7:0]               cell_char,
    output logic [7:0]               cell_attribute,
    // configuration
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    cmd_t       cmd;
    res_t       res;
    logic       res_valid;
    logic       res_ready;
    logic [7:0] def_attr_reg;
    logic       out_valid_reg;
    res_t       out_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            def_attr_reg <= DEFAULT_ATTR_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_DEFAULT_ATTR))
        begin
            def_attr_reg <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DEFAULT_ATTR) ? {24'd0, def_attr_reg} : 32'd0;

    // request packing
    always_comb
    begin
        cmd.mode         = mode_t'(mode);
        cmd.character    = character;
        cmd.attribute    = attribute;
        cmd.use_position = use_position;
        cmd.column       = column;
        cmd.line         = line;
        cmd.count        = count;
    end

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (in_valid),
        .cmd_stall    (in_stall),
        .cmd          (cmd),
        .default_attr (def_attr_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    // output register
    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign cursor_cell    = out_reg.cursor_cell;
    assign scrolled       = out_reg.scrolled;
    assign cell_char      = out_reg.cell_char;
    assign cell_attribute = out_reg.cell_attribute;

endmodule

`default_nettype wire

// File: sv/tcw_cell_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_cell_ram #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 16
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // one write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // one registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/tcw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cmd_valid,
    output logic            cmd_stall,
    input  wire cmd_t       cmd,
    input  wire logic [7:0] default_attr,
    output logic            res_valid,
    input  wire logic       res_ready,
    output res_t            res
);

    localparam int CELLS      = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int CNT_W      = $clog2(CELLS + 1);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int LAST_BASE  = (ROWS - 1) * COLUMNS;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] cur_idx_reg, cur_idx_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ADDR_W-1:0] t_idx_reg, t_idx_next;
    logic [ROW_W-1:0]  t_row_reg, t_row_next;
    logic [COL_W-1:0]  t_col_reg, t_col_next;
    mode_t             mode_reg, mode_next;
    logic [7:0]        char_reg, char_next;
    logic [7:0]        attr_reg, attr_next;
    logic [7:0]        left_reg, left_next;
    logic [CNT_W-1:0]  rp_reg, rp_next;
    logic [CNT_W-1:0]  wp_reg, wp_next;
    logic              pend_reg, pend_next;
    logic              scr_reg, scr_next;
    logic [7:0]        rchar_reg, rchar_next;
    logic [7:0]        rattr_reg, rattr_next;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [15:0]       wdata;
    logic [ADDR_W-1:0] raddr;
    logic [15:0]       rdata;
    logic              fin;
    logic [COL_W-1:0]  sat_col;
    logic [ROW_W-1:0]  sat_row;
    logic              is_newline;

    // cell store
    tcw_cell_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W),
        .DATA_W (16)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // position saturation on the request fields
    always_comb
    begin
        sat_col = ({2'b00, cmd.column} >= 9'(COLUMNS)) ? COL_W'(COLUMNS - 1)
                                                      : COL_W'(cmd.column);
        sat_row = ({3'b000, cmd.line} >= 8'(ROWS)) ? ROW_W'(ROWS - 1)
                                                   : ROW_W'(cmd.line);
        is_newline = (cmd.mode == MODE_WRITE) && (cmd.character == CHAR_NEWLINE);
    end

    // control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            cur_idx_reg <= '0;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            wp_reg      <= '0;
            rp_reg      <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_idx_reg <= cur_idx_next;
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            pend_reg    <= pend_next;
        end
    end

    // request payload and result registers
    always_ff @(posedge clk)
    begin
        t_idx_reg <= t_idx_next;
        t_row_reg <= t_row_next;
        t_col_reg <= t_col_next;
        mode_reg  <= mode_next;
        char_reg  <= char_next;
        attr_reg  <= attr_next;
        left_reg  <= left_next;
        scr_reg   <= scr_next;
        rchar_reg <= rchar_next;
        rattr_reg <= rattr_next;
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        cur_idx_next = cur_idx_reg;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        t_idx_next   = t_idx_reg;
        t_row_next   = t_row_reg;
        t_col_next   = t_col_reg;
        mode_next    = mode_reg;
        char_next    = char_reg;
        attr_next    = attr_reg;
        left_next    = left_reg;
        rp_next      = rp_reg;
        wp_next      = wp_reg;
        pend_next    = pend_reg;
        scr_next     = scr_reg;
        rchar_next   = rchar_reg;
        rattr_next   = rattr_reg;
        we           = 1'b0;
        waddr        = wp_reg[ADDR_W-1:0];
        wdata        = '0;
        raddr        = t_idx_reg;
        fin          = 1'b0;

        unique case (state_reg)
            // clearing pass after reset
            S_INIT:
            begin
                we      = 1'b1;
                wp_next = wp_reg + 1'b1;
                if (wp_reg == CNT_W'(CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            // take a request
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    mode_next  = cmd.mode;
                    char_next  = cmd.character;
                    attr_next  = (cmd.attribute == 8'd0) ? default_attr : cmd.attribute;
                    left_next  = cmd.count;
                    scr_next   = 1'b0;
                    rchar_next = 8'd0;
                    rattr_next = 8'd0;
                    t_idx_next = cur_idx_reg;
                    if (cmd.use_position)
                    begin
                        t_row_next = sat_row;
                        t_col_next = sat_col;
                    end
                    else
                    begin
                        t_row_next = cur_row_reg;
                        t_col_next = cur_col_reg;
                    end
                    if (is_newline)
                    begin
                        t_col_next = COL_W'(COLUMNS - 1);
                    end
                    unique case (cmd.mode)
                        MODE_WRITE, MODE_READ:
                        begin
                            if (cmd.use_position || is_newline)
                            begin
                                state_next = S_MUL;
                            end
                            else
                            begin
                                state_next = S_EXEC;
                            end
                        end
                        MODE_ERASE:
                        begin
                            state_next = S_ERASE_RD;
                        end
                        MODE_CLEAR:
                        begin
                            wp_next    = '0;
                            state_next = S_FILL;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // cell index from row and column
            S_MUL:
            begin
                t_idx_next = ADDR_W'(t_row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(t_col_reg);
                state_next = S_EXEC;
            end

            // write the cell and advance, or issue the read
            S_EXEC:
            begin
                if (mode_reg == MODE_READ)
                begin
                    state_next = S_RD_WAIT;
                end
                else
                begin
                    if (char_reg != CHAR_NEWLINE)
                    begin
                        we    = 1'b1;
                        waddr = t_idx_reg;
                        wdata = {attr_reg, char_reg};
                    end
                    if (t_col_reg == COL_W'(COLUMNS - 1))
                    begin
                        cur_col_next = '0;
                        if (t_row_reg == ROW_W'(ROWS - 1))
                        begin
                            cur_idx_next = ADDR_W'(LAST_BASE);
                            cur_row_next = ROW_W'(ROWS - 1);
                            scr_next     = 1'b1;
                            rp_next      = CNT_W'(COLUMNS);
                            wp_next      = '0;
                            pend_next    = 1'b0;
                            state_next   = S_SCROLL;
                        end
                        else
                        begin
                            cur_idx_next = t_idx_reg + 1'b1;
                            cur_row_next = t_row_reg + 1'b1;
                            fin          = 1'b1;
                        end
                    end
                    else
                    begin
                        cur_idx_next = t_idx_reg + 1'b1;
                        cur_row_next = t_row_reg;
                        cur_col_next = t_col_reg + 1'b1;
                        fin          = 1'b1;
                    end
                end
            end

            // read data is back
            S_RD_WAIT:
            begin
                rchar_next = rdata[7:0];
                rattr_next = rdata[15:8];
                fin        = 1'b1;
            end

            // erase: fetch the cell before the cursor
            S_ERASE_RD:
            begin
                raddr = cur_idx_reg - 1'b1;
                if ((left_reg == 8'd0) || (cur_idx_reg == '0))
                begin
                    fin = 1'b1;
                end
                else
                begin
                    state_next = S_ERASE_WR;
                end
            end

            // erase: blank it, keep its attribute, step back
            S_ERASE_WR:
            begin
                we           = 1'b1;
                waddr        = cur_idx_reg - 1'b1;
                wdata        = {rdata[15:8], CHAR_SPACE};
                cur_idx_next = cur_idx_reg - 1'b1;
                left_next    = left_reg - 1'b1;
                if (cur_col_reg == '0)
                begin
                    cur_col_next = COL_W'(COLUMNS - 1);
                    cur_row_next = cur_row_reg - 1'b1;
                end
                else
                begin
                    cur_col_next = cur_col_reg - 1'b1;
                end
                state_next = S_ERASE_RD;
            end

            // clear screen sweep
            S_FILL:
            begin
                we      = 1'b1;
                wdata   = {default_attr, CHAR_SPACE};
                wp_next = wp_reg + 1'b1;
                if (wp_reg == CNT_W'(CELLS - 1))
                begin
                    cur_idx_next = '0;
                    cur_row_next = '0;
                    cur_col_next = '0;
                    fin          = 1'b1;
                end
            end

            // scroll copy: read one row ahead, write each cell in the cycle after its read
            S_SCROLL:
            begin
                raddr = rp_reg[ADDR_W-1:0];
                if (rp_reg != CNT_W'(CELLS))
                begin
                    rp_next   = rp_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    we      = 1'b1;
                    wdata   = rdata;
                    wp_next = wp_reg + 1'b1;
                end
                if ((rp_reg == CNT_W'(CELLS)) && !pend_reg)
                begin
                    state_next = S_ZERO;
                end
            end

            // zero the last row
            S_ZERO:
            begin
                we      = 1'b1;
                wp_next = wp_reg + 1'b1;
                if (wp_reg == CNT_W'(CELLS - 1))
                begin
                    fin = 1'b1;
                end
            end

            // result waits for the output register
            S_DONE:
            begin
                fin = 1'b1;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // hand over the result
        if (fin)
        begin
            state_next = res_ready ? S_IDLE : S_DONE;
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = fin;

    always_comb
    begin
        res.cursor_cell    = CURSOR_W'(cur_idx_next);
        res.scrolled       = scr_next;
        res.cell_char      = rchar_next;
        res.cell_attribute = rattr_next;
    end

endmodule

`default_nettype wire

// File: bench/text_console_writer_core_tb.sv
`timescale 1ns / 1ps

// expected screen contents and results, kept alongside the block
class console_scoreboard;
    localparam int COLS   = 80;
    localparam int ROWS_N = 25;
    localparam int CELLS  = COLS * ROWS_N;

    logic [15:0]     cells [CELLS];
    int unsigned     cur;
    logic [7:0]      dflt_attr;
    tcw_pkg::res_t   pending [$];
    int unsigned     errors;

    function new();
        foreach (cells[i])
            cells[i] = 16'h0000;
        cur       = 0;
        dflt_attr = tcw_pkg::DEFAULT_ATTR_RESET;
        errors    = 0;
    endfunction

    // cell addressed by a request, positions saturate at the screen edge
    function int unsigned target_cell(logic up, logic [6:0] col, logic [4:0] ln);
        int unsigned c;
        int unsigned r;
        if (!up)
            return cur;
        c = (col >= COLS) ? COLS - 1 : col;
        r = (ln >= ROWS_N) ? ROWS_N - 1 : ln;
        return r * COLS + c;
    endfunction

    // works out the result of one accepted request and queues it
    function void note_request(tcw_pkg::cmd_t c);
        tcw_pkg::res_t r;
        int unsigned   pos;
        int unsigned   k;
        logic [7:0]    a;
        r = '0;
        case (c.mode)
            tcw_pkg::MODE_WRITE:
            begin
                pos = target_cell(c.use_position, c.column, c.line);
                a   = (c.attribute == 8'd0) ? dflt_attr : c.attribute;
                if (c.character == tcw_pkg::CHAR_NEWLINE)
                    pos = (pos / COLS) * COLS + (COLS - 1);
                else
                    cells[pos] = {a, c.character};
                pos++;
                // scroll up one row once the cursor runs off the end
                if (pos >= CELLS)
                begin
                    for (int i = 0; i + COLS < CELLS; i++)
                        cells[i] = cells[i + COLS];
                    for (int i = CELLS - COLS; i < CELLS; i++)
                        cells[i] = 16'h0000;
                    pos -= COLS;
                    r.scrolled = 1'b1;
                end
                cur = pos;
            end
            tcw_pkg::MODE_ERASE:
            begin
                k = (c.count < cur) ? c.count : cur;
                for (int i = 1; i <= k; i++)
                    cells[cur - i] = {cells[cur - i][15:8], tcw_pkg::CHAR_SPACE};
                cur -= k;
            end
            tcw_pkg::MODE_CLEAR:
            begin
                foreach (cells[i])
                    cells[i] = {dflt_attr, tcw_pkg::CHAR_SPACE};
                cur = 0;
            end
            default:
            begin
                pos = target_cell(c.use_position, c.column, c.line);
                r.cell_char      = cells[pos][7:0];
                r.cell_attribute = cells[pos][15:8];
            end
        endcase
        r.cursor_cell = cur[tcw_pkg::CURSOR_W-1:0];
        pending.push_back(r);
    endfunction

    function void report(string what, int unsigned expv, int unsigned actv);
        errors++;
        if (errors <= 200)
            $display("%0t: %s expected %0d actual %0d", $time, what, expv, actv);
    endfunction

    // compares one accepted result with the oldest expectation
    function void check_result(tcw_pkg::res_t got);
        tcw_pkg::res_t exp_r;
        if (pending.size() == 0)
        begin
            report("unexpected result, cursor_cell", 0, got.cursor_cell);
            return;
        end
        exp_r = pending.pop_front();
        if (got.cursor_cell !== exp_r.cursor_cell)
            report("cursor_cell", exp_r.cursor_cell, got.cursor_cell);
        if (got.scrolled !== exp_r.scrolled)
            report("scrolled", exp_r.scrolled, got.scrolled);
        if (got.cell_char !== exp_r.cell_char)
            report("cell_char", exp_r.cell_char, got.cell_char);
        if (got.cell_attribute !== exp_r.cell_attribute)
            report("cell_attribute", exp_r.cell_attribute, got.cell_attribute);
    endfunction
endclass

module text_console_writer_core_tb;
    import tcw_pkg::*;

    localparam int COLS        = 80;
    localparam int ROWS_N      = 25;
    localparam int RAND_ITEMS  = 100;
    localparam int HOLD_CYCLES = 600;
    localparam int CYCLE_LIMIT = 10000000;

    logic clk = 1'b0;
    logic rst_n;

    logic                in_valid;
    logic                in_stall;
    logic [1:0]          mode;
    logic [7:0]          character;
    logic [7:0]          attribute;
    logic                use_position;
    logic [6:0]          column;
    logic [4:0]          line;
    logic [7:0]          count;
    logic                out_valid;
    logic                out_stall;
    logic [CURSOR_W-1:0] cursor_cell;
    logic                scrolled;
    logic [7:0]          cell_char;
    logic [7:0]          cell_attribute;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    console_scoreboard sb = new();

    int unsigned send_idle_pct;
    int unsigned stall_pct;
    logic        hold_req;
    int unsigned hold_left;
    int unsigned cycle_count;

    text_console_writer_core #(
        .COLUMNS(COLS),
        .ROWS   (ROWS_N)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .character     (character),
        .attribute     (attribute),
        .use_position  (use_position),
        .column        (column),
        .line          (line),
        .count         (count),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cursor_cell   (cursor_cell),
        .scrolled      (scrolled),
        .cell_char     (cell_char),
        .cell_attribute(cell_attribute),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // note each accepted request and check each accepted result
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_request({mode_t'(mode), character, attribute, use_position,
                             column, line, count});
        if (rst_n && out_valid && !out_stall)
            sb.check_result({cursor_cell, scrolled, cell_char, cell_attribute});
    end

    // receiver: random stalls, or a long hold-off when asked
    initial
    begin
        hold_req  = 1'b0;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic cmd_t make_cmd(mode_t m, logic [7:0] ch, logic [7:0] a,
                                      logic up, logic [6:0] col, logic [4:0] ln,
                                      logic [7:0] cnt);
        cmd_t c;
        c.mode         = m;
        c.character    = ch;
        c.attribute    = a;
        c.use_position = up;
        c.column       = col;
        c.line         = ln;
        c.count        = cnt;
        return c;
    endfunction

    // random request, mostly writes and reads, with rare clears
    function automatic cmd_t rand_request();
        int unsigned sel;
        mode_t       m;
        logic [7:0]  ch;
        logic [7:0]  a;
        logic [7:0]  cnt;
        sel = $urandom_range(99);
        if (sel < 55)
            m = MODE_WRITE;
        else if (sel < 65)
            m = MODE_ERASE;
        else if (sel < 68)
            m = MODE_CLEAR;
        else
            m = MODE_READ;
        ch  = ($urandom_range(99) < 15) ? CHAR_NEWLINE : 8'($urandom_range(255));
        a   = ($urandom_range(99) < 30) ? 8'd0 : 8'($urandom_range(255));
        cnt = ($urandom_range(1)) ? 8'($urandom_range(8)) : 8'($urandom_range(255));
        return make_cmd(m, ch, a, 1'($urandom_range(1)), 7'($urandom_range(127)),
                        5'($urandom_range(31)), cnt);
    endfunction

    // offer one request and wait until it is taken
    task automatic send_request(input cmd_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= c.mode;
        character    <= c.character;
        attribute    <= c.attribute;
        use_position <= c.use_position;
        column       <= c.column;
        line         <= c.line;
        count        <= c.count;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
    endtask

    // write the default attribute register and read it back
    task automatic cfg_write(input logic [7:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(REG_DEFAULT_ATTR) << 2;
        pwdata  <= {24'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.dflt_attr = val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[7:0] !== val)
            sb.report("default_attribute readback", val, prdata[7:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // one random phase under a given idling pattern and default attribute
    task automatic run_phase(input int unsigned s_pct, input int unsigned r_pct,
                             input logic [7:0] dattr, input logic pressure);
        wait_drained();
        cfg_write(dattr);
        send_idle_pct = s_pct;
        stall_pct     = r_pct;
        if (pressure)
            hold_req = 1'b1;
        repeat (RAND_ITEMS)
            send_request(rand_request());
        in_valid <= 1'b0;
    endtask

    initial
    begin
        cmd_t directed [$];

        send_idle_pct = 0;
        stall_pct     = 0;
        cycle_count   = 0;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        mode         <= MODE_WRITE;
        character    <= 8'd0;
        attribute    <= 8'd0;
        use_position <= 1'b0;
        column       <= 7'd0;
        line         <= 5'd0;
        count        <= 8'd0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= 3'd0;
        pwdata       <= 32'd0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;

        // directed requests: field extremes, saturation, newline, scroll, erase limits
        directed.push_back(make_cmd(MODE_WRITE, 8'h41, 8'h00, 1'b0, 7'd0, 5'd0, 8'd0));
        directed.push_back(make_cmd(MODE_WRITE, 8'hFF, 8'hFF, 1'b0, 7'd127, 5'd31, 8'd255));
        directed.push_back(make_cmd(MODE_READ, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0, 8'd0));
        directed.push_back(make_cmd(MODE_READ, 8'hFF, 8'hFF, 1'b1, 7'd0, 5'd0, 8'd255));
        directed.push_back(make_cmd(MODE_WRITE, 8'h5A, 8'h12, 1'b1, 7'd78, 5'd24, 8'd0));
        directed.push_back(make_cmd(MODE_WRITE, 8'h7E, 8'h34, 1'b1, 7'd127, 5'd31, 8'd0));
        directed.push_back(make_cmd(MODE_READ, 8'h00, 8'h00, 1'b1, 7'd78, 5'd23, 8'd0));
        directed.push_back(make_cmd(MODE_READ, 8'h00, 8'h00, 1'b1, 7'd79, 5'd24, 8'd0));
        directed.push_back(make_cmd(MODE_WRITE, CHAR_NEWLINE, 8'h00, 1'b0, 7'd0, 5'd0,
                                    8'd0));
        directed.push_back(make_cmd(MODE_WRITE, CHAR_NEWLINE, 8'h56, 1'b1, 7'd3, 5'd24,
                                    8'd0));
        directed.push_back(make_cmd(MODE_WRITE, 8'h00, 8'h00, 1'b1, 7'd80, 5'd25, 8'd0));
        directed.push_back(make_cmd(MODE_WRITE, 8'h42, 8'h00, 1'b1, 7'd10, 5'd2, 8'd0));
        directed.push_back(make_cmd(MODE_WRITE, 8'h43, 8'h77, 1'b0, 7'd0, 5'd0, 8'd0));
        directed.push_back(make_cmd(MODE_ERASE, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0, 8'd0));
        directed.push_back(make_cmd(MODE_ERASE, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0, 8'd1));
        directed.push_back(make_cmd(MODE_READ, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0, 8'd0));
        directed.push_back(make_cmd(MODE_ERASE, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0, 8'd255));
        directed.push_back(make_cmd(MODE_ERASE, 8'hFF, 8'hFF, 1'b1, 7'd127, 5'd31, 8'd5));
        directed.push_back(make_cmd(MODE_READ, 8'h00, 8'h00, 1'b1, 7'd10, 5'd2, 8'd0));
        directed.push_back(make_cmd(MODE_CLEAR, 8'hFF, 8'hFF, 1'b1, 7'd127, 5'd31, 8'd255));
        directed.push_back(make_cmd(MODE_READ, 8'h00, 8'h00, 1'b1, 7'd40, 5'd12, 8'd0));
        directed.push_back(make_cmd(MODE_CLEAR, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0, 8'd0));
        directed.push_back(make_cmd(MODE_READ, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0, 8'd0));

        cfg_write(8'd200);
        foreach (directed[i])
            send_request(directed[i]);
        in_valid <= 1'b0;

        // random phases: zero default, sender gaps, receiver stalls, both, back-pressure
        run_phase(0, 0, 8'd0, 1'b0);
        run_phase(55, 0, 8'd255, 1'b0);
        run_phase(0, 55, 8'($urandom_range(1, 254)), 1'b0);
        run_phase(7, 7, 8'($urandom_range(255)), 1'b0);
        run_phase(0, 0, 8'd1, 1'b1);
        run_phase(55, 55, DEFAULT_ATTR_RESET, 1'b0);

        wait_drained();
        repeat (50)
            @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// File: sim.f
sv/tcw_pkg.sv
sv/tcw_cell_ram.sv
sv/tcw_ctrl.sv
sv/text_console_writer_core.sv
bench/text_console_writer_core_tb.sv
